/* src/klx_pkg.sv */
package klx_pkg;

  // Width of the position counters. Output fields stay 16 bits and clamp.
  localparam int POS_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam int NUM_KW = 10;

  // Character codes
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Token kinds
  localparam logic [4:0] KIND_TIMES    = 5'd0;
  localparam logic [4:0] KIND_PLUS     = 5'd1;
  localparam logic [4:0] KIND_MINUS    = 5'd2;
  localparam logic [4:0] KIND_LESS     = 5'd3;
  localparam logic [4:0] KIND_EQUAL    = 5'd4;
  localparam logic [4:0] KIND_COLON    = 5'd5;
  localparam logic [4:0] KIND_LPAREN   = 5'd6;
  localparam logic [4:0] KIND_RPAREN   = 5'd7;
  localparam logic [4:0] KIND_SEMISEMI = 5'd8;
  localparam logic [4:0] KIND_INTEGER  = 5'd9;
  localparam logic [4:0] KIND_KW0      = 5'd10;
  localparam logic [4:0] KIND_IDENT    = 5'd20;
  localparam logic [4:0] KIND_ERROR    = 5'd21;
  localparam logic [4:0] KIND_END      = 5'd22;

  // Keywords packed high byte first: int bool true false fun is if then else let
  localparam logic [39:0] KW_PACK [NUM_KW] = '{
    40'h0000696E74, 40'h00626F6F6C, 40'h0074727565, 40'h66616C7365,
    40'h000066756E, 40'h0000006973, 40'h0000006966, 40'h007468656E,
    40'h00656C7365, 40'h00006C6574
  };

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_IDENT,
    MODE_SEMI,
    MODE_DEAD
  } mode_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line_no;
    logic [15:0] start_pos;
    logic [15:0] tok_len;
  } tok_t;

  // Up to three tokens from one character, in order from slot 0.
  typedef struct packed {
    tok_t [2:0] slot;
    logic [1:0] cnt;
  } bundle_t;

  function automatic logic [15:0] clamp16(input logic [POS_W-1:0] v);
    if (v > POS_W'(32'hFFFF)) begin
      return 16'hFFFF;
    end
    return 16'(v);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_TIMES) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_LESS) ||
           (c == CH_EQUAL) || (c == CH_COLON) || (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      CH_TIMES:  k = KIND_TIMES;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_LESS:   k = KIND_LESS;
      CH_EQUAL:  k = KIND_EQUAL;
      CH_COLON:  k = KIND_COLON;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default:   k = KIND_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic ident_cont(input logic [7:0] c);
    return (c != CH_RPAREN) && (c != CH_LPAREN) && (c != CH_COLON) && (c != CH_SEMI) &&
           (c != CH_SPACE) && (c != CH_TAB) && (c != CH_NL);
  endfunction

  // Append a byte; a sixth byte saturates the word to all ones.
  function automatic logic [39:0] pack_byte(input logic [39:0] w, input logic [7:0] c);
    logic [7:0] b;
    b = (c == CH_NUL) ? 8'hFF : c;
    if (w[39:32] != 8'h00) begin
      return '1;
    end
    return {w[31:0], b};
  endfunction

  function automatic logic [4:0] word_kind(input logic [39:0] w);
    logic [4:0] k;
    k = KIND_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (w == KW_PACK[i]) begin
        k = 5'(KIND_KW0 + 5'(i));
      end
    end
    return k;
  endfunction

endpackage

/* src/klx_ifs.sv */
interface klx_src_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       final_req;

  modport source (output valid, ch, final_req, input ready);
  modport sink (input valid, ch, final_req, output ready);
endinterface

interface klx_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [15:0] line_no;
  logic [15:0] start_pos;
  logic [15:0] tok_len;
  logic        run_last;

  modport source (output valid, kind, line_no, start_pos, tok_len, run_last, input ready);
  modport sink (input valid, kind, line_no, start_pos, tok_len, run_last, output ready);
endinterface

/* src/klx_scan.sv */
module klx_scan (
  input  logic              clk,
  input  logic              rst,
  klx_src_if.sink           src,
  input  logic              load_ok,
  output klx_pkg::bundle_t  bun,
  output logic              bun_valid
);

  logic                        stage_valid;
  logic [7:0]                  cur_ch;
  logic                        cur_fin;
  logic                        adv;

  klx_pkg::mode_t              mode, mode_next, mode_scan, mode_two;
  logic [klx_pkg::POS_W-1:0]   position, position_next, nxt;
  logic [klx_pkg::POS_W-1:0]   token_begin, token_begin_next, tb_two;
  logic [15:0]                 line_count, line_count_next, line_two;
  logic [39:0]                 word_prefix, word_prefix_next, pre_two;

  logic is_digit, is_semi, is_nl, is_sep, op_c, cont, start_id, scan;

  klx_pkg::tok_t [3:0] ev;
  logic [3:0]          ev_en;
  logic [2:0]          n;

  // character classes
  assign is_digit = (cur_ch >= klx_pkg::CH_ZERO) && (cur_ch <= klx_pkg::CH_NINE);
  assign is_semi  = cur_ch == klx_pkg::CH_SEMI;
  assign is_nl    = cur_ch == klx_pkg::CH_NL;
  assign is_sep   = (cur_ch == klx_pkg::CH_SPACE) || (cur_ch == klx_pkg::CH_TAB);
  assign op_c     = klx_pkg::is_op(cur_ch);
  assign cont     = klx_pkg::ident_cont(cur_ch);
  assign start_id = !op_c && !is_semi && !is_nl && !is_sep && !is_digit;

  assign scan = (mode == klx_pkg::MODE_IDLE) ||
                ((mode == klx_pkg::MODE_INT) && !is_digit) ||
                ((mode == klx_pkg::MODE_IDENT) && !cont);

  assign nxt = (position == klx_pkg::POS_MAX) ? position :
               position + {{(klx_pkg::POS_W-1){1'b0}}, 1'b1};

  always_comb begin
    if (op_c || is_nl || is_sep) begin
      mode_scan = klx_pkg::MODE_IDLE;
    end else if (is_semi) begin
      mode_scan = klx_pkg::MODE_SEMI;
    end else if (is_digit) begin
      mode_scan = klx_pkg::MODE_INT;
    end else begin
      mode_scan = klx_pkg::MODE_IDENT;
    end
  end

  // state after this character, before end-of-text handling
  always_comb begin
    case (mode)
      klx_pkg::MODE_SEMI:  mode_two = is_semi ? klx_pkg::MODE_IDLE : klx_pkg::MODE_DEAD;
      klx_pkg::MODE_DEAD:  mode_two = klx_pkg::MODE_DEAD;
      klx_pkg::MODE_INT:   mode_two = is_digit ? klx_pkg::MODE_INT : mode_scan;
      klx_pkg::MODE_IDENT: mode_two = cont ? klx_pkg::MODE_IDENT : mode_scan;
      default:             mode_two = mode_scan;
    endcase
    if ((mode == klx_pkg::MODE_IDENT) && cont) begin
      pre_two = klx_pkg::pack_byte(word_prefix, cur_ch);
    end else if (scan && start_id) begin
      pre_two = klx_pkg::pack_byte(40'h0, cur_ch);
    end else begin
      pre_two = word_prefix;
    end
    tb_two   = (scan && (is_semi || is_digit || start_id)) ? position : token_begin;
    line_two = (scan && is_nl && (line_count != 16'hFFFF)) ? line_count + 16'd1 : line_count;
  end

  // next state
  always_comb begin
    if (cur_fin) begin
      mode_next        = klx_pkg::MODE_IDLE;
      position_next    = '0;
      token_begin_next = '0;
      line_count_next  = 16'd1;
      word_prefix_next = '0;
    end else begin
      mode_next        = mode_two;
      position_next    = nxt;
      token_begin_next = tb_two;
      line_count_next  = line_two;
      word_prefix_next = pre_two;
    end
  end

  // tokens: run close or ';' outcome, operator, end-of-text close, end marker
  always_comb begin
    ev_en[0]          = (mode == klx_pkg::MODE_SEMI) ||
                        ((mode == klx_pkg::MODE_INT) && !is_digit) ||
                        ((mode == klx_pkg::MODE_IDENT) && !cont);
    ev[0].line_no     = line_count;
    ev[0].start_pos   = klx_pkg::clamp16(token_begin);
    case (mode)
      klx_pkg::MODE_SEMI: begin
        ev[0].kind    = is_semi ? klx_pkg::KIND_SEMISEMI : klx_pkg::KIND_ERROR;
        ev[0].tok_len = is_semi ? klx_pkg::clamp16(nxt - token_begin) : 16'd1;
      end
      klx_pkg::MODE_INT: begin
        ev[0].kind    = klx_pkg::KIND_INTEGER;
        ev[0].tok_len = klx_pkg::clamp16(position - token_begin);
      end
      default: begin
        ev[0].kind    = klx_pkg::word_kind(word_prefix);
        ev[0].tok_len = klx_pkg::clamp16(position - token_begin);
      end
    endcase

    ev_en[1]        = scan && op_c;
    ev[1].kind      = klx_pkg::op_kind(cur_ch);
    ev[1].line_no   = line_count;
    ev[1].start_pos = klx_pkg::clamp16(position);
    ev[1].tok_len   = 16'd1;

    ev_en[2]        = cur_fin && ((mode_two == klx_pkg::MODE_INT) ||
                      (mode_two == klx_pkg::MODE_IDENT) || (mode_two == klx_pkg::MODE_SEMI));
    ev[2].line_no   = line_two;
    ev[2].start_pos = klx_pkg::clamp16(tb_two);
    case (mode_two)
      klx_pkg::MODE_INT: begin
        ev[2].kind    = klx_pkg::KIND_INTEGER;
        ev[2].tok_len = klx_pkg::clamp16(nxt - tb_two);
      end
      klx_pkg::MODE_IDENT: begin
        ev[2].kind    = klx_pkg::word_kind(pre_two);
        ev[2].tok_len = klx_pkg::clamp16(nxt - tb_two);
      end
      default: begin
        ev[2].kind    = klx_pkg::KIND_ERROR;
        ev[2].tok_len = 16'd1;
      end
    endcase

    ev_en[3]        = cur_fin && (mode_two != klx_pkg::MODE_DEAD) &&
                      (mode_two != klx_pkg::MODE_SEMI);
    ev[3].kind      = klx_pkg::KIND_END;
    ev[3].line_no   = line_two;
    ev[3].start_pos = klx_pkg::clamp16(nxt);
    ev[3].tok_len   = 16'd0;
  end

  // compact enabled tokens into slots; at most three are ever enabled
  always_comb begin
    bun = '0;
    n   = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (ev_en[i]) begin
        if (n < 3'd3) begin
          bun.slot[n[1:0]] = ev[i];
        end
        n = n + 3'd1;
      end
    end
    bun.cnt = n[1:0];
  end

  assign bun_valid = stage_valid && (bun.cnt != 2'd0);
  assign adv       = stage_valid && ((bun.cnt == 2'd0) || load_ok);
  assign src.ready = !stage_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (src.ready) begin
      stage_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      cur_ch  <= src.ch;
      cur_fin <= src.final_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= klx_pkg::MODE_IDLE;
      position    <= '0;
      token_begin <= '0;
      line_count  <= 16'd1;
      word_prefix <= '0;
    end else if (adv) begin
      mode        <= mode_next;
      position    <= position_next;
      token_begin <= token_begin_next;
      line_count  <= line_count_next;
      word_prefix <= word_prefix_next;
    end
  end

endmodule

/* src/klx_outq.sv */
module klx_outq (
  input  logic              clk,
  input  logic              rst,
  input  klx_pkg::bundle_t  bun,
  input  logic              bun_valid,
  output logic              load_ok,
  klx_tok_if.source         tok
);

  klx_pkg::bundle_t held;
  logic [1:0]       idx;
  logic             busy;
  logic             last;
  logic             pop;
  klx_pkg::tok_t    cur;

  assign last    = idx == (held.cnt - 2'd1);
  assign pop     = busy && tok.ready;
  assign load_ok = !busy || (pop && last);
  assign cur     = held.slot[idx];

  assign tok.valid     = busy;
  assign tok.kind      = cur.kind;
  assign tok.line_no   = cur.line_no;
  assign tok.start_pos = cur.start_pos;
  assign tok.tok_len   = cur.tok_len;
  assign tok.run_last  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load_ok) begin
      busy <= bun_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && bun_valid) begin
      held <= bun;
      idx  <= 2'd0;
    end else if (pop) begin
      idx  <= idx + 2'd1;
    end
  end

endmodule

/* src/keyword_lexer_token_stream_core.sv */
// Keyword lexer: one source character per item in on src, tokens out on tok
// (kind, line, start offset, length, and run_last on the last token that a
// character causes). A character is registered, then decoded against a small
// mode register and a parallel compare with the ten keywords; the tokens it
// yields (none to three) are registered in an output buffer that shows one
// per cycle while tok is ready. The input takes one character per cycle as
// long as each gives at most one token and tok is ready; a character giving
// several tokens keeps the buffer busy until all are taken, and the input
// stalls once the buffer and the decode register are both full. A lone ';'
// yields an error token and silences the rest of the text, end marker
// included; final_req closes any open run, emits the end token and returns
// all counters to their reset values for the next text. Offsets, lengths and
// line numbers saturate at 65535.
module keyword_lexer_token_stream_core (
  input logic       clk,
  input logic       rst,
  klx_src_if.sink   src,
  klx_tok_if.source tok
);

  klx_pkg::bundle_t bun;
  logic             bun_valid;
  logic             load_ok;

  // decode stage: character register, scanner state, token compaction
  klx_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .src       (src),
    .load_ok   (load_ok),
    .bun       (bun),
    .bun_valid (bun_valid)
  );

  // result buffer: emits the held tokens one per cycle while tok is ready
  klx_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .bun       (bun),
    .bun_valid (bun_valid),
    .load_ok   (load_ok),
    .tok       (tok)
  );

endmodule

/* src/klx_check.sv */
module klx_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_kind,
  input logic [15:0] out_tok_len,
  input logic [15:0] out_line_no,
  input logic        out_run_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_tok_len))
    else $error("token changed while stalled");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == klx_pkg::KIND_END) |-> out_run_last && (out_tok_len == 16'd0))
    else $error("end token not last or has length");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == klx_pkg::KIND_ERROR) |-> out_run_last && (out_tok_len == 16'd1))
    else $error("error token malformed");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind <= klx_pkg::KIND_END) && (out_line_no != 16'd0))
    else $error("token kind or line out of range");

  a_op_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind <= klx_pkg::KIND_RPAREN) |-> out_tok_len == 16'd1)
    else $error("operator length not one");

endmodule

bind keyword_lexer_token_stream_core klx_check u_klx_check (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tok.valid),
  .out_ready    (tok.ready),
  .out_kind     (tok.kind),
  .out_tok_len  (tok.tok_len),
  .out_line_no  (tok.line_no),
  .out_run_last (tok.run_last)
);
